>>> sv/ptc_pkg.sv
// ----------------------------------------------------------------------------
// ptc_pkg
// Shared types and constants for the page table translator with clock
// replacement: table and resident list geometry, status codes, entry layouts.
// ----------------------------------------------------------------------------
package ptc_pkg;

	localparam int MAX_INDEX_BITS  = 8;
	localparam int MAX_FRAME_BITS  = 6;
	localparam int MAX_OFFSET_BITS = 12;

	localparam int TABLE_DEPTH = 1 << MAX_INDEX_BITS;
	localparam int RES_DEPTH   = 1 << MAX_FRAME_BITS;

	localparam int ADDR_W = 20;
	localparam int PA_W   = MAX_FRAME_BITS + MAX_OFFSET_BITS;

	// input word commands
	localparam logic CMD_LOAD      = 1'b0;
	localparam logic CMD_TRANSLATE = 1'b1;

	// configuration register indexes
	typedef enum logic [1:0] {
		CFG_OFFSET_BITS = 2'd0,
		CFG_INDEX_BITS  = 2'd1,
		CFG_FRAME_BITS  = 2'd2
	} cfg_reg_t;

	// result status codes
	typedef enum logic [2:0] {
		ST_LOADED   = 3'd0,
		ST_HIT      = 3'd1,
		ST_REPLACED = 3'd2,
		ST_SEGFAULT = 3'd3,
		ST_NO_FRAME = 3'd4,
		ST_FULL     = 3'd5
	} status_t;

	// control sequence
	typedef enum logic [2:0] {
		S_IDLE,
		S_LOOK,
		S_SWEEP_RD,
		S_SWEEP_CHK,
		S_FIX,
		S_RESP
	} state_t;

	// page table entry; resident/slot point at the resident list slot holding the page
	typedef struct packed {
		logic                      valid;
		logic                      perm;
		logic [MAX_FRAME_BITS-1:0] frame;
		logic                      resident;
		logic [MAX_FRAME_BITS-1:0] slot;
	} page_entry_t;

	// resident list slot
	typedef struct packed {
		logic [MAX_INDEX_BITS-1:0] page;
		logic [MAX_FRAME_BITS-1:0] frame;
		logic                      used;
	} slot_t;

endpackage

>>> sv/page_table_translate_clock_replace_top.sv
// ----------------------------------------------------------------------------
// page_table_translate_clock_replace_top
// Single-level page table with a clock (second chance) replacement sweep over
// the list of resident frames.
// ----------------------------------------------------------------------------
// One word is worked on at a time. A load goes from acceptance to the result
// register; a translate reads its page table entry and then ends as a hit, a
// segfault or no resident frame, and a page fault first runs the clock hand over
// the resident slots (it visits at most the resident count plus one) and then
// writes the new page's entry. Each visit is a read of the resident list memory
// followed by a check that writes the slot back; the page table and resident
// list memories have registered reads.
// A finished result sits in an output register, so the next word is taken
// while it waits. The page table and resident list come up unwritten; no
// clearing pass runs after reset.
// ----------------------------------------------------------------------------
module page_table_translate_clock_replace_top (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write port
	input  logic        cfg_write,
	input  logic [1:0]  cfg_index,
	input  logic [3:0]  cfg_data,
	// input channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        command,
	input  logic [19:0] address,
	input  logic        entry_valid,
	input  logic        entry_perm,
	input  logic [5:0]  entry_frame,
	input  logic        entry_use,
	// output channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [17:0] phys_address,
	output logic        truncated,
	output logic [7:0]  evicted_page
);

	localparam int IW = ptc_pkg::MAX_INDEX_BITS;
	localparam int FW = ptc_pkg::MAX_FRAME_BITS;
	localparam int OW = ptc_pkg::MAX_OFFSET_BITS;

	// configuration registers, raw values
	logic [3:0] off_raw_q;
	logic [3:0] idx_raw_q;
	logic [2:0] frm_raw_q;

	// clamped configuration
	logic [3:0] off_c;
	logic [3:0] idx_c;
	logic [2:0] frm_c;
	logic [4:0] tot_c;
	logic [FW-1:0] fmask_c;

	// address split
	logic [19:0] amask_c;
	logic [19:0] addr_c;
	logic [19:0] page_shift_c;
	logic        tr_c;
	logic [OW-1:0] offv_c;
	logic [IW-1:0] page_c;

	// load path
	logic          full_c;
	logic          append_c;
	logic [FW-1:0] frame_in_c;

	// control state
	ptc_pkg::state_t state_q, state_d;
	logic [IW:0]   lc_q;
	logic [FW:0]   rc_q;
	logic [FW-1:0] hand_q;
	logic          out_valid_q;
	logic          in_take;
	logic          out_free;

	// item registers
	logic [IW-1:0]         page_q;
	logic [OW-1:0]         offv_q;
	logic                  tr_q;
	ptc_pkg::page_entry_t  fix_entry_q;

	// result registers
	ptc_pkg::status_t res_status_q;
	logic [17:0]      res_pa_q;
	logic [IW-1:0]    res_ev_q;

	// output registers
	ptc_pkg::status_t out_status_q;
	logic [17:0]      out_pa_q;
	logic             out_tr_q;
	logic [IW-1:0]    out_ev_q;

	// memories
	ptc_pkg::page_entry_t page_mem [ptc_pkg::TABLE_DEPTH];
	ptc_pkg::slot_t       slot_mem [ptc_pkg::RES_DEPTH];
	ptc_pkg::page_entry_t pg_rdata_q;
	ptc_pkg::slot_t       sl_rdata_q;

	// memory access controls
	logic                 pg_we, pg_re;
	logic [IW-1:0]        pg_waddr, pg_raddr;
	ptc_pkg::page_entry_t pg_wdata;
	logic                 sl_we, sl_re;
	logic [FW-1:0]        sl_waddr, sl_raddr;
	ptc_pkg::slot_t       sl_wdata;

	// datapath controls
	logic             res_we;
	ptc_pkg::status_t res_status_d;
	logic [17:0]      res_pa_d;
	logic [IW-1:0]    res_ev_d;
	logic             lc_inc, rc_inc;
	logic             hand_we;
	logic [FW-1:0]    hand_d;
	logic             fix_we;
	ptc_pkg::page_entry_t fix_entry_d;

	// hand arithmetic
	logic [FW:0]   hand_inc;
	logic [FW-1:0] hand_adv;
	logic [FW-1:0] hand_fix;

	// physical address of a table hit and of a replaced slot
	logic [17:0] pa_hit_c;
	logic [17:0] pa_evict_c;

	// clamp configuration into range
	always_comb begin
		off_c = (off_raw_q > 4'(OW)) ? 4'(OW) : off_raw_q;
		if (idx_raw_q == 4'd0)
			idx_c = 4'd1;
		else if (idx_raw_q > 4'(IW))
			idx_c = 4'(IW);
		else
			idx_c = idx_raw_q;
		if (frm_raw_q == 3'd0)
			frm_c = 3'd1;
		else if (frm_raw_q > 3'(FW))
			frm_c = 3'(FW);
		else
			frm_c = frm_raw_q;
	end

	assign tot_c   = {1'b0, idx_c} + {1'b0, off_c};
	assign fmask_c = ~({FW{1'b1}} << frm_c);

	// split the virtual address into page and offset
	assign amask_c      = ~(20'hFFFFF << tot_c);
	assign tr_c         = |(address & ~amask_c);
	assign addr_c       = address & amask_c;
	assign offv_c       = addr_c[OW-1:0] & ~({OW{1'b1}} << off_c);
	assign page_shift_c = addr_c >> off_c;
	assign page_c       = page_shift_c[IW-1:0];

	// load path decisions
	assign full_c     = lc_q >= ((IW+1)'(1) << idx_c);
	assign append_c   = entry_valid & entry_perm & (rc_q < (FW+1)'(ptc_pkg::RES_DEPTH));
	assign frame_in_c = entry_frame & fmask_c;

	// clock hand wrap
	assign hand_inc = {1'b0, hand_q} + (FW+1)'(1);
	assign hand_adv = (hand_inc >= rc_q) ? '0 : hand_inc[FW-1:0];
	assign hand_fix = ({1'b0, hand_q} >= rc_q) ? '0 : hand_q;

	assign pa_hit_c   = ({12'd0, pg_rdata_q.frame & fmask_c} << off_c) | {6'd0, offv_q};
	assign pa_evict_c = ({12'd0, sl_rdata_q.frame & fmask_c} << off_c) | {6'd0, offv_q};

	// handshake
	assign in_stall = (state_q != ptc_pkg::S_IDLE);
	assign in_take  = in_valid & ~in_stall;
	assign out_free = ~out_valid_q | ~out_stall;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ptc_pkg::S_IDLE: begin
				if (in_take)
					state_d = (command == ptc_pkg::CMD_TRANSLATE) ?
						ptc_pkg::S_LOOK : ptc_pkg::S_RESP;
			end
			ptc_pkg::S_LOOK: begin
				if (pg_rdata_q.perm && !pg_rdata_q.valid && rc_q != '0)
					state_d = ptc_pkg::S_SWEEP_RD;
				else
					state_d = ptc_pkg::S_RESP;
			end
			ptc_pkg::S_SWEEP_RD: begin
				state_d = ptc_pkg::S_SWEEP_CHK;
			end
			ptc_pkg::S_SWEEP_CHK: begin
				state_d = sl_rdata_q.used ? ptc_pkg::S_SWEEP_RD : ptc_pkg::S_FIX;
			end
			ptc_pkg::S_FIX: begin
				state_d = ptc_pkg::S_RESP;
			end
			ptc_pkg::S_RESP: begin
				if (out_free)
					state_d = ptc_pkg::S_IDLE;
			end
			default: state_d = ptc_pkg::S_IDLE;
		endcase
	end

	// memory accesses and result updates per state
	always_comb begin
		pg_we        = 1'b0;
		pg_waddr     = page_q;
		pg_wdata     = fix_entry_q;
		pg_re        = 1'b0;
		pg_raddr     = page_c;
		sl_we        = 1'b0;
		sl_waddr     = hand_q;
		sl_wdata     = sl_rdata_q;
		sl_re        = 1'b0;
		sl_raddr     = hand_q;
		res_we       = 1'b0;
		res_status_d = ptc_pkg::ST_LOADED;
		res_pa_d     = '0;
		res_ev_d     = '0;
		lc_inc       = 1'b0;
		rc_inc       = 1'b0;
		hand_we      = 1'b0;
		hand_d       = hand_adv;
		fix_we       = 1'b0;
		fix_entry_d  = fix_entry_q;
		unique case (state_q)
			ptc_pkg::S_IDLE: begin
				if (in_take && command == ptc_pkg::CMD_LOAD) begin
					res_we = 1'b1;
					if (full_c) begin
						res_status_d = ptc_pkg::ST_FULL;
					end else begin
						res_status_d = ptc_pkg::ST_LOADED;
						pg_we    = 1'b1;
						pg_waddr = lc_q[IW-1:0];
						pg_wdata = '{valid: entry_valid, perm: entry_perm,
							frame: frame_in_c, resident: append_c, slot: rc_q[FW-1:0]};
						lc_inc   = 1'b1;
						if (append_c) begin
							sl_we    = 1'b1;
							sl_waddr = rc_q[FW-1:0];
							sl_wdata = '{page: lc_q[IW-1:0], frame: frame_in_c,
								used: entry_use};
							rc_inc   = 1'b1;
						end
					end
				end else if (in_take) begin
					pg_re    = 1'b1;
					pg_raddr = page_c;
				end
			end
			ptc_pkg::S_LOOK: begin
				if (!pg_rdata_q.perm) begin
					res_we       = 1'b1;
					res_status_d = ptc_pkg::ST_SEGFAULT;
				end else if (pg_rdata_q.valid) begin
					res_we       = 1'b1;
					res_status_d = ptc_pkg::ST_HIT;
					res_pa_d     = pa_hit_c;
					// mark the slot that holds this page as recently used
					if (pg_rdata_q.resident) begin
						sl_we    = 1'b1;
						sl_waddr = pg_rdata_q.slot;
						sl_wdata = '{page: page_q, frame: pg_rdata_q.frame, used: 1'b1};
					end
				end else if (rc_q == '0) begin
					res_we       = 1'b1;
					res_status_d = ptc_pkg::ST_NO_FRAME;
				end else begin
					hand_we = 1'b1;
					hand_d  = hand_fix;
				end
			end
			ptc_pkg::S_SWEEP_RD: begin
				sl_re    = 1'b1;
				sl_raddr = hand_q;
			end
			ptc_pkg::S_SWEEP_CHK: begin
				hand_we  = 1'b1;
				hand_d   = hand_adv;
				sl_we    = 1'b1;
				sl_waddr = hand_q;
				if (sl_rdata_q.used) begin
					// second chance: clear the use bit and move on
					sl_wdata = '{page: sl_rdata_q.page, frame: sl_rdata_q.frame, used: 1'b0};
				end else begin
					// evict: the slot takes the new page, the old page goes invalid
					sl_wdata     = '{page: page_q, frame: sl_rdata_q.frame, used: 1'b1};
					pg_we        = 1'b1;
					pg_waddr     = sl_rdata_q.page;
					pg_wdata     = '{valid: 1'b0, perm: 1'b1, frame: sl_rdata_q.frame,
						resident: 1'b0, slot: '0};
					res_we       = 1'b1;
					res_status_d = ptc_pkg::ST_REPLACED;
					res_pa_d     = pa_evict_c;
					res_ev_d     = sl_rdata_q.page;
					fix_we       = 1'b1;
					fix_entry_d  = '{valid: 1'b1, perm: 1'b1, frame: sl_rdata_q.frame,
						resident: 1'b1, slot: hand_q};
				end
			end
			ptc_pkg::S_FIX: begin
				// second table write of a replacement: the new page's entry
				pg_we    = 1'b1;
				pg_waddr = page_q;
				pg_wdata = fix_entry_q;
			end
			ptc_pkg::S_RESP: begin
			end
			default: begin
			end
		endcase
	end

	// page table memory
	always_ff @(posedge clk) begin
		if (pg_we)
			page_mem[pg_waddr] <= pg_wdata;
		if (pg_re)
			pg_rdata_q <= page_mem[pg_raddr];
	end

	// resident list memory
	always_ff @(posedge clk) begin
		if (sl_we)
			slot_mem[sl_waddr] <= sl_wdata;
		if (sl_re)
			sl_rdata_q <= slot_mem[sl_raddr];
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ptc_pkg::S_IDLE;
			lc_q        <= '0;
			rc_q        <= '0;
			hand_q      <= '0;
			out_valid_q <= 1'b0;
			off_raw_q   <= 4'd8;
			idx_raw_q   <= 4'd8;
			frm_raw_q   <= 3'd6;
		end else begin
			state_q <= state_d;
			if (lc_inc)
				lc_q <= lc_q + (IW+1)'(1);
			if (rc_inc)
				rc_q <= rc_q + (FW+1)'(1);
			if (hand_we)
				hand_q <= hand_d;
			if (state_q == ptc_pkg::S_RESP && out_free)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			if (cfg_write) begin
				unique case (ptc_pkg::cfg_reg_t'(cfg_index))
					ptc_pkg::CFG_OFFSET_BITS: off_raw_q <= cfg_data;
					ptc_pkg::CFG_INDEX_BITS:  idx_raw_q <= cfg_data;
					ptc_pkg::CFG_FRAME_BITS:  frm_raw_q <= cfg_data[2:0];
					default: begin
					end
				endcase
			end
		end
	end

	// item and result registers
	always_ff @(posedge clk) begin
		if (in_take) begin
			page_q <= page_c;
			offv_q <= offv_c;
			tr_q   <= (command == ptc_pkg::CMD_TRANSLATE) & tr_c;
		end
		if (res_we) begin
			res_status_q <= res_status_d;
			res_pa_q     <= res_pa_d;
			res_ev_q     <= res_ev_d;
		end
		if (fix_we)
			fix_entry_q <= fix_entry_d;
		if (state_q == ptc_pkg::S_RESP && out_free) begin
			out_status_q <= res_status_q;
			out_pa_q     <= res_pa_q;
			out_tr_q     <= tr_q;
			out_ev_q     <= res_ev_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = out_status_q;
	assign phys_address = out_pa_q;
	assign truncated    = out_tr_q;
	assign evicted_page = out_ev_q;

endmodule

>>> sv/ptc_checker.sv
// ----------------------------------------------------------------------------
// ptc_checker
// Port-level checks for the page table translator, bound to the top level.
// ----------------------------------------------------------------------------
module ptc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        cfg_write,
	input logic [1:0]  cfg_index,
	input logic [3:0]  cfg_data,
	input logic        in_valid,
	input logic        in_stall,
	input logic        command,
	input logic [19:0] address,
	input logic        entry_valid,
	input logic        entry_perm,
	input logic [5:0]  entry_frame,
	input logic        entry_use,
	input logic        out_valid,
	input logic        out_stall,
	input logic [2:0]  status,
	input logic [17:0] phys_address,
	input logic        truncated,
	input logic [7:0]  evicted_page
);

	// a stalled result word holds its value
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(phys_address)
			&& $stable(evicted_page) && $stable(truncated))
		else $error("stalled result word changed");

	// only hits and replacements carry a physical address
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ptc_pkg::ST_HIT && status != ptc_pkg::ST_REPLACED
			|-> phys_address == '0)
		else $error("physical address on a result without translation");

	// only replacements name an evicted page
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ptc_pkg::ST_REPLACED |-> evicted_page == '0)
		else $error("evicted page on a result without replacement");

	// load results never flag truncation
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ptc_pkg::ST_LOADED || status == ptc_pkg::ST_FULL)
			|-> !truncated)
		else $error("truncation flagged on a load result");

	// the block takes one word at a time: an accepted word stalls the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input accepted on consecutive cycles");

endmodule

bind page_table_translate_clock_replace_top ptc_checker u_ptc_checker (.*);
